@@ hdl/lock_order_deadlock_detector_defines.svh @@
// ----------------------------------------------------------------------------
// lock order deadlock detector assertion macros
// ----------------------------------------------------------------------------
`ifndef LOCK_ORDER_DEADLOCK_DETECTOR_DEFINES_SVH
`define LOCK_ORDER_DEADLOCK_DETECTOR_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define LODD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define LODD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ hdl/lodd_pkg.sv @@
// ----------------------------------------------------------------------------
// lodd_pkg
// shared types and codes of the lock order deadlock detector
// ----------------------------------------------------------------------------
package lodd_pkg;

   typedef logic [2:0] status_type;

   localparam status_type ST_OK           = 3'd0;
   localparam status_type ST_DEADLOCK     = 3'd1;
   localparam status_type ST_MULTI_UNLOCK = 3'd2;
   localparam status_type ST_BAD_UNLOCK   = 3'd3;
   localparam status_type ST_TABLE_FULL   = 3'd4;
   localparam status_type ST_OVERFLOW     = 3'd5;
   localparam status_type ST_HALTED       = 3'd6;

   localparam logic MODE_ACQUIRE = 1'b0;
   localparam logic MODE_RELEASE = 1'b1;

   localparam int TAG_W = 16;
   localparam int IDX_W = 5;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOOK_RD,
      S_LOOK_CMP,
      S_HOLD_CHK,
      S_HTOP_CMP,
      S_EDGE_CHK,
      S_ROOT,
      S_ROW,
      S_SCAN,
      S_POP,
      S_PUSH,
      S_RESP
   } state_type;

endpackage

@@ hdl/lodd_channels_if.sv @@
// ----------------------------------------------------------------------------
// lodd channels
// valid/ready channels for lock events and their results
// ----------------------------------------------------------------------------
interface lodd_req_if import lodd_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               mode;
   logic [TAG_W-1:0]   lock_tag;

   modport source (output valid, output mode, output lock_tag, input ready);
   modport sink (input valid, input mode, input lock_tag, output ready);
endinterface

interface lodd_rsp_if import lodd_pkg::*; ();
   logic               valid;
   logic               ready;
   status_type         status;
   logic [IDX_W-1:0]   lock_index;
   logic [IDX_W-1:0]   cycle_from;
   logic [IDX_W-1:0]   cycle_to;

   modport source (output valid, output status, output lock_index, output cycle_from,
                   output cycle_to, input ready);
   modport sink (input valid, input status, input lock_index, input cycle_from,
                 input cycle_to, output ready);
endinterface

@@ hdl/lock_order_deadlock_detector.sv @@
// ----------------------------------------------------------------------------
// lock_order_deadlock_detector
// Takes lock acquire/release transactions on req_chan and answers each with
// exactly one result transaction on rsp_chan (status, lock index, back edge).
// Tags are looked up one table entry at a time (S_LOOK_RD, then S_LOOK_CMP).
// A new ordering edge starts a depth-first search that tests one adjacency
// bit per cycle in S_SCAN, pausing in S_ROW to fetch a row on each push and
// in S_POP and S_ROW on each pop. Halted items and empty-stack releases go
// from idle to the result; items scanning the edge matrix take the longest.
// req_chan.ready is high only while the sequencer is idle, one item at a
// time. The result sits in an output register; the sequencer may already
// accept the next transaction, and holds a finished result in place while
// the receiver stalls. Reset clears the known count, stack depth, edge row
// valid bits and the sticky fault; tables need no clearing pass. After any
// error every later transaction answers halted until reset.
// ----------------------------------------------------------------------------
module lock_order_deadlock_detector import lodd_pkg::*; #(
   parameter int MAX_LOCKS  = 32,
   parameter int HOLD_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   lodd_req_if.sink   req_chan,
   lodd_rsp_if.source rsp_chan
);

   localparam int IW  = $clog2(MAX_LOCKS);
   localparam int CW  = IW + 1;
   localparam int HW  = $clog2(HOLD_DEPTH);
   localparam int DW  = HW + 1;
   localparam int WKW = IW + CW;

   state_type           state_ff, state_in;
   logic                mode_ff, mode_in;
   logic [TAG_W-1:0]    tag_ff, tag_in;
   logic [IW-1:0]       id_ff, id_in;
   logic [CW-1:0]       idx_ff, idx_in;
   logic [CW-1:0]       known_ff, known_in;
   logic [DW-1:0]       depth_ff, depth_in;
   logic                fault_ff, fault_in;
   logic [MAX_LOCKS-1:0] edge_valid_ff, edge_valid_in;
   logic [MAX_LOCKS-1:0] seen_ff, seen_in;
   logic [MAX_LOCKS-1:0] done_ff, done_in;
   logic [MAX_LOCKS-1:0] row_ff, row_in;
   logic [CW-1:0]       root_ff, root_in;
   logic [IW-1:0]       here_ff, here_in;
   logic [CW-1:0]       cursor_ff, cursor_in;
   logic [IW-1:0]       sp_ff, sp_in;
   logic [IW-1:0]       prev_ff, prev_in;
   status_type          res_status_ff, res_status_in;
   logic [IDX_W-1:0]    res_index_ff, res_index_in;
   logic [IDX_W-1:0]    res_from_ff, res_from_in;
   logic [IDX_W-1:0]    res_to_ff, res_to_in;
   logic                rsp_valid_ff, rsp_valid_in;
   status_type          rsp_status_ff, rsp_status_in;
   logic [IDX_W-1:0]    rsp_index_ff, rsp_index_in;
   logic [IDX_W-1:0]    rsp_from_ff, rsp_from_in;
   logic [IDX_W-1:0]    rsp_to_ff, rsp_to_in;

   logic                tag_we;
   logic [IW-1:0]       tag_waddr, tag_raddr;
   logic [TAG_W-1:0]    tag_rdata;
   logic                held_we;
   logic [HW-1:0]       held_waddr, held_raddr;
   logic [IW-1:0]       held_rdata;
   logic                edge_we;
   logic [IW-1:0]       edge_waddr, edge_raddr;
   logic [MAX_LOCKS-1:0] edge_wdata, edge_rdata, edge_row;
   logic                walk_we;
   logic [IW-1:0]       walk_waddr, walk_raddr;
   logic [WKW-1:0]      walk_wdata, walk_rdata;
   logic [MAX_LOCKS-1:0] id_bit;
   logic [IW-1:0]       scan_j;

   lodd_ram #(.WIDTH(TAG_W), .DEPTH(MAX_LOCKS)) u_tag_ram (
      .clock(clock), .wr_en(tag_we), .wr_addr(tag_waddr), .wr_data(tag_ff),
      .rd_addr(tag_raddr), .rd_data(tag_rdata));

   lodd_ram #(.WIDTH(IW), .DEPTH(HOLD_DEPTH)) u_held_ram (
      .clock(clock), .wr_en(held_we), .wr_addr(held_waddr), .wr_data(id_ff),
      .rd_addr(held_raddr), .rd_data(held_rdata));

   lodd_ram #(.WIDTH(MAX_LOCKS), .DEPTH(MAX_LOCKS)) u_edge_ram (
      .clock(clock), .wr_en(edge_we), .wr_addr(edge_waddr), .wr_data(edge_wdata),
      .rd_addr(edge_raddr), .rd_data(edge_rdata));

   lodd_ram #(.WIDTH(WKW), .DEPTH(MAX_LOCKS)) u_walk_ram (
      .clock(clock), .wr_en(walk_we), .wr_addr(walk_waddr), .wr_data(walk_wdata),
      .rd_addr(walk_raddr), .rd_data(walk_rdata));

   assign id_bit = {{(MAX_LOCKS-1){1'b0}}, 1'b1} << id_ff;
   assign scan_j = cursor_ff[IW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         known_ff      <= '0;
         depth_ff      <= '0;
         fault_ff      <= 1'b0;
         edge_valid_ff <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         known_ff      <= known_in;
         depth_ff      <= depth_in;
         fault_ff      <= fault_in;
         edge_valid_ff <= edge_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      mode_ff       <= mode_in;
      tag_ff        <= tag_in;
      id_ff         <= id_in;
      idx_ff        <= idx_in;
      seen_ff       <= seen_in;
      done_ff       <= done_in;
      row_ff        <= row_in;
      root_ff       <= root_in;
      here_ff       <= here_in;
      cursor_ff     <= cursor_in;
      sp_ff         <= sp_in;
      prev_ff       <= prev_in;
      res_status_ff <= res_status_in;
      res_index_ff  <= res_index_in;
      res_from_ff   <= res_from_in;
      res_to_ff     <= res_to_in;
      rsp_status_ff <= rsp_status_in;
      rsp_index_ff  <= rsp_index_in;
      rsp_from_ff   <= rsp_from_in;
      rsp_to_ff     <= rsp_to_in;
   end

   always_comb begin
      state_in      = state_ff;
      mode_in       = mode_ff;
      tag_in        = tag_ff;
      id_in         = id_ff;
      idx_in        = idx_ff;
      known_in      = known_ff;
      depth_in      = depth_ff;
      fault_in      = fault_ff;
      edge_valid_in = edge_valid_ff;
      seen_in       = seen_ff;
      done_in       = done_ff;
      row_in        = row_ff;
      root_in       = root_ff;
      here_in       = here_ff;
      cursor_in     = cursor_ff;
      sp_in         = sp_ff;
      prev_in       = prev_ff;
      res_status_in = res_status_ff;
      res_index_in  = res_index_ff;
      res_from_in   = res_from_ff;
      res_to_in     = res_to_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_index_in  = rsp_index_ff;
      rsp_from_in   = rsp_from_ff;
      rsp_to_in     = rsp_to_ff;

      tag_we     = 1'b0;
      tag_waddr  = known_ff[IW-1:0];
      tag_raddr  = idx_ff[IW-1:0];
      held_we    = 1'b0;
      held_waddr = depth_ff[HW-1:0];
      held_raddr = HW'(depth_ff - 1'b1);
      edge_we    = 1'b0;
      edge_waddr = prev_ff;
      edge_wdata = '0;
      edge_raddr = here_ff;
      walk_we    = 1'b0;
      walk_waddr = sp_ff;
      walk_wdata = {here_ff, cursor_ff + 1'b1};
      walk_raddr = sp_ff - 1'b1;
      edge_row   = edge_valid_ff[here_ff] ? edge_rdata : '0;

      req_chan.ready = 1'b0;

      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            req_chan.ready = 1'b1;
            if (req_chan.valid) begin
               mode_in       = req_chan.mode;
               tag_in        = req_chan.lock_tag;
               idx_in        = '0;
               res_status_in = ST_OK;
               res_index_in  = '0;
               res_from_in   = '0;
               res_to_in     = '0;
               if (fault_ff) begin
                  res_status_in = ST_HALTED;
                  state_in      = S_RESP;
               end else if (req_chan.mode == MODE_RELEASE && depth_ff == '0) begin
                  res_status_in = ST_MULTI_UNLOCK;
                  fault_in      = 1'b1;
                  state_in      = S_RESP;
               end else begin
                  state_in = S_LOOK_RD;
               end
            end
         end
         S_LOOK_RD: begin
            if (idx_ff == known_ff) begin
               // tag not in table
               if (mode_ff == MODE_RELEASE) begin
                  res_status_in = ST_BAD_UNLOCK;
                  fault_in      = 1'b1;
                  state_in      = S_RESP;
               end else if (known_ff == CW'(MAX_LOCKS)) begin
                  res_status_in = ST_TABLE_FULL;
                  fault_in      = 1'b1;
                  state_in      = S_RESP;
               end else begin
                  tag_we   = 1'b1;
                  id_in    = known_ff[IW-1:0];
                  known_in = known_ff + 1'b1;
                  state_in = S_HOLD_CHK;
               end
            end else begin
               state_in = S_LOOK_CMP;
            end
         end
         S_LOOK_CMP: begin
            if (tag_rdata == tag_ff) begin
               id_in    = idx_ff[IW-1:0];
               state_in = S_HOLD_CHK;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = S_LOOK_RD;
            end
         end
         S_HOLD_CHK: begin
            res_index_in = IDX_W'(id_ff);
            // held ram read of the top entry is issued here
            if (mode_ff == MODE_ACQUIRE && depth_ff == '0) begin
               state_in = S_PUSH;
            end else begin
               state_in = S_HTOP_CMP;
            end
         end
         S_HTOP_CMP: begin
            if (mode_ff == MODE_RELEASE) begin
               if (held_rdata != id_ff) begin
                  res_status_in = ST_BAD_UNLOCK;
                  fault_in      = 1'b1;
               end else begin
                  depth_in = depth_ff - 1'b1;
               end
               state_in = S_RESP;
            end else if (held_rdata == id_ff) begin
               state_in = S_PUSH;
            end else begin
               prev_in    = held_rdata;
               edge_raddr = held_rdata;
               state_in   = S_EDGE_CHK;
            end
         end
         S_EDGE_CHK: begin
            edge_row = edge_valid_ff[prev_ff] ? edge_rdata : '0;
            if ((edge_row & id_bit) != '0) begin
               state_in = S_PUSH;
            end else begin
               edge_we                = 1'b1;
               edge_wdata             = edge_row | id_bit;
               edge_valid_in[prev_ff] = 1'b1;
               seen_in                = '0;
               done_in                = '0;
               root_in                = '0;
               state_in               = S_ROOT;
            end
         end
         S_ROOT: begin
            if (root_ff == known_ff) begin
               state_in = S_PUSH;
            end else if (seen_ff[root_ff[IW-1:0]]) begin
               root_in = root_ff + 1'b1;
            end else begin
               seen_in[root_ff[IW-1:0]] = 1'b1;
               here_in    = root_ff[IW-1:0];
               cursor_in  = '0;
               sp_in      = '0;
               edge_raddr = root_ff[IW-1:0];
               state_in   = S_ROW;
            end
         end
         S_ROW: begin
            row_in   = edge_row;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            if (cursor_ff >= known_ff) begin
               // every successor visited, retire this lock
               done_in[here_ff] = 1'b1;
               if (sp_ff == '0) begin
                  root_in  = root_ff + 1'b1;
                  state_in = S_ROOT;
               end else begin
                  sp_in    = sp_ff - 1'b1;
                  state_in = S_POP;
               end
            end else if (!row_ff[scan_j]) begin
               cursor_in = cursor_ff + 1'b1;
            end else if (!seen_ff[scan_j]) begin
               seen_in[scan_j] = 1'b1;
               walk_we    = 1'b1;
               sp_in      = sp_ff + 1'b1;
               here_in    = scan_j;
               cursor_in  = '0;
               edge_raddr = scan_j;
               state_in   = S_ROW;
            end else if (!done_ff[scan_j]) begin
               // successor still on the walk path: back edge
               res_status_in = ST_DEADLOCK;
               res_from_in   = IDX_W'(here_ff);
               res_to_in     = IDX_W'(scan_j);
               fault_in      = 1'b1;
               state_in      = S_RESP;
            end else begin
               cursor_in = cursor_ff + 1'b1;
            end
         end
         S_POP: begin
            here_in    = walk_rdata[WKW-1:CW];
            cursor_in  = walk_rdata[CW-1:0];
            edge_raddr = walk_rdata[WKW-1:CW];
            state_in   = S_ROW;
         end
         S_PUSH: begin
            if (depth_ff == DW'(HOLD_DEPTH)) begin
               res_status_in = ST_OVERFLOW;
               fault_in      = 1'b1;
            end else begin
               held_we  = 1'b1;
               depth_in = depth_ff + 1'b1;
            end
            state_in = S_RESP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_index_in  = res_index_ff;
               rsp_from_in   = res_from_ff;
               rsp_to_in     = res_to_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.status     = rsp_status_ff;
   assign rsp_chan.lock_index = rsp_index_ff;
   assign rsp_chan.cycle_from = rsp_from_ff;
   assign rsp_chan.cycle_to   = rsp_to_ff;

endmodule

@@ hdl/lodd_ram.sv @@
// ----------------------------------------------------------------------------
// lodd_ram
// simple dual port ram, one write and one read port, registered read
// ----------------------------------------------------------------------------
module lodd_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/lodd_checker.sv @@
// ----------------------------------------------------------------------------
// lodd_checker
// port level checks of the lock order deadlock detector
// ----------------------------------------------------------------------------
`include "lock_order_deadlock_detector_defines.svh"

module lodd_checker import lodd_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input status_type       rsp_status,
   input logic [IDX_W-1:0] rsp_lock_index,
   input logic [IDX_W-1:0] rsp_cycle_from,
   input logic [IDX_W-1:0] rsp_cycle_to
);

   logic fault_seen_ff;
   logic rsp_take;

   assign rsp_take = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fault_seen_ff <= 1'b0;
      end else if (rsp_take && rsp_status != ST_OK) begin
         fault_seen_ff <= 1'b1;
      end
   end

   `LODD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_lock_index), "result changed while stalled")
   `LODD_ASSERT_NOW(a_sticky_fault, fault_seen_ff && rsp_take, rsp_status == ST_HALTED, "result after a fault is not halted")
   `LODD_ASSERT_NOW(a_edge_zero, rsp_valid && rsp_status != ST_DEADLOCK, rsp_cycle_from == '0 && rsp_cycle_to == '0, "back edge fields set without deadlock")
   `LODD_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "ready stayed high after a transaction")

endmodule

bind lock_order_deadlock_detector lodd_checker u_lodd_checker (
   .clock(clock),
   .reset(reset),
   .req_valid(req_chan.valid),
   .req_ready(req_chan.ready),
   .rsp_valid(rsp_chan.valid),
   .rsp_ready(rsp_chan.ready),
   .rsp_status(rsp_chan.status),
   .rsp_lock_index(rsp_chan.lock_index),
   .rsp_cycle_from(rsp_chan.cycle_from),
   .rsp_cycle_to(rsp_chan.cycle_to)
);
